[hw/rtl/edd_pkg.sv]
// ============================================================================
// edd_pkg - shared types and constants of the error diffusion distributor
// Register map codes, derived-matrix bundle, derivation FSM states, widths.
// ============================================================================
`default_nettype none

package edd_pkg;

    localparam int STORED_DIM  = 5;      // weight rows/cols held in registers
    localparam int WEIGHT_W    = 4;
    localparam int ROW_W       = STORED_DIM * WEIGHT_W;
    localparam int IMG_W       = 13;
    localparam int ERR_W       = 9;
    localparam int PLANE_W     = 2;
    localparam int SHARE_W     = 9;
    localparam int SUM_W       = 9;      // at most 25 * 15
    localparam int IDX_W       = 3;      // matrix row/col index, dim up to 8
    localparam int NUM_W       = 13;     // sum/2 + w*err, signed
    localparam int MAG_W       = 12;     // |numerator| < 4096
    localparam int RECIP_SHIFT = 21;     // MAG_W + 9 (sum < 512)
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIV_CNT_W   = 5;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_WEIGHT_0   = 3'd0,
        REG_WEIGHT_1   = 3'd1,
        REG_WEIGHT_2   = 3'd2,
        REG_WEIGHT_3   = 3'd3,
        REG_WEIGHT_4   = 3'd4,
        REG_IMAGE_ROWS = 3'd5,
        REG_IMAGE_COLS = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_SWEEP,
        DRV_DIVIDE
    } drv_state_t;

    typedef logic [STORED_DIM-1:0][ROW_W-1:0] weight_rows_t;

    // Matrix properties worked out after each weight write
    typedef struct packed {
        logic                 enable;   // matrix usable
        logic [SUM_W-1:0]     sum;
        logic [IDX_W-1:0]     crow;
        logic [IDX_W-1:0]     ccol;
        logic [RECIP_W-1:0]   recip;    // ceil(2^RECIP_SHIFT / sum)
    } mtx_info_t;

    // weight at (r, c); entries outside the stored 5x5 read as zero
    function automatic logic [WEIGHT_W-1:0] weight_at(weight_rows_t rows, int r, int c);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        if (r < STORED_DIM && c < STORED_DIM)
        begin
            w = rows[r][WEIGHT_W*c +: WEIGHT_W];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/error_diffusion_distributor.sv]
// ============================================================================
// error_diffusion_distributor - error diffusion neighbour update generator
// Spreads one pixel's quantization error over a configurable weight matrix
// and emits one (row, col, plane, share) update per cycle for pending items.
// ============================================================================
//
//  channel   direction  handshake              word
//  -------   ---------  ---------------------  -------------------------------
//  command   in         start && !busy         quant_error, mirror, pixel_row,
//                                              pixel_col, color_plane
//  update    out        update_strobe (1 clk)  target_row, target_col,
//                                              target_plane, share, last_update
//  config    in/out     APB, pready tied high  weight_row_0..4, image_rows/cols
//
//  Flow: the back end issues one update per cycle; an item has 1..24 updates
//  for a 5x5 matrix, whose top-left weight is zero, and the next item follows
//  with no gap. With the block idle, an accepted item's first update passes
//  through the front word, the queue, the issue mask and stages A and B
//  (share stage), in that order, before it is on the ports.
//  Items that produce no update are dropped by the front in their accept cycle.
//  After any weight write the block is busy while the matrix sweep and the
//  reciprocal division of the weight sum run; the division is skipped when
//  the new matrix is unusable.
//  Reset: asynchronous, active low; weights clear to zero (no updates), image
//  size to 4096; no derivation pass is needed after reset.
//  Stalls: the update side cannot stall; busy rises only during derivation or
//  when the two-word queue and the front word are both full.
//
`default_nettype none

module error_diffusion_distributor import edd_pkg::*; #(
    parameter int MATRIX_DIM = 5,
    parameter int COORD_BITS = 12,
    parameter int PIXEL_MAX  = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // command
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ERR_W-1:0]       quant_error,
    input  wire logic                          mirror,
    input  wire logic        [COORD_BITS-1:0]  pixel_row,
    input  wire logic        [COORD_BITS-1:0]  pixel_col,
    input  wire logic        [PLANE_W-1:0]     color_plane,
    // updates
    output logic                               update_strobe,
    output logic             [COORD_BITS-1:0]  target_row,
    output logic             [COORD_BITS-1:0]  target_col,
    output logic             [PLANE_W-1:0]     target_plane,
    output logic signed      [SHARE_W-1:0]     share,
    output logic                               last_update,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic        [APB_ADDR_W-1:0]  paddr,
    input  wire logic        [APB_DATA_W-1:0]  pwdata,
    output logic             [APB_DATA_W-1:0]  prdata,
    output logic                               pready
);

    localparam int N      = MATRIX_DIM * MATRIX_DIM;
    localparam int QW     = N + ERR_W + 1 + 2 * COORD_BITS + PLANE_W;
    localparam int QDEPTH = 2;

    weight_rows_t            weights;
    logic [IMG_W-1:0]        image_rows, image_cols;
    mtx_info_t               mtx;
    logic                    deriving;

    // front -> queue
    logic                    push;
    logic [N-1:0]            p_mask;
    logic signed [ERR_W-1:0] p_err;
    logic                    p_mirror;
    logic [COORD_BITS-1:0]   p_row, p_col;
    logic [PLANE_W-1:0]      p_plane;

    // queue -> back
    logic                    pop, q_full, q_empty;
    logic [QW-1:0]           q_din, q_dout;
    logic [N-1:0]            q_mask;
    logic signed [ERR_W-1:0] q_err;
    logic                    q_mirror;
    logic [COORD_BITS-1:0]   q_row, q_col;
    logic [PLANE_W-1:0]      q_plane;

    edd_cfg #(
        .MATRIX_DIM (MATRIX_DIM)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .weights    (weights),
        .image_rows (image_rows),
        .image_cols (image_cols),
        .mtx        (mtx),
        .deriving   (deriving)
    );

    // front: accept, validate the error, mask off-image and zero entries
    edd_front #(
        .MATRIX_DIM (MATRIX_DIM),
        .COORD_BITS (COORD_BITS),
        .PIXEL_MAX  (PIXEL_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .quant_error (quant_error),
        .mirror      (mirror),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .color_plane (color_plane),
        .weights     (weights),
        .image_rows  (image_rows),
        .image_cols  (image_cols),
        .mtx         (mtx),
        .deriving    (deriving),
        .q_full      (q_full),
        .push        (push),
        .p_mask      (p_mask),
        .p_err       (p_err),
        .p_mirror    (p_mirror),
        .p_row       (p_row),
        .p_col       (p_col),
        .p_plane     (p_plane)
    );

    assign q_din = {p_mask, p_err, p_mirror, p_row, p_col, p_plane};
    assign {q_mask, q_err, q_mirror, q_row, q_col, q_plane} = q_dout;

    edd_fifo #(
        .WIDTH (QW),
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .pop   (pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    // back: one update per cycle, share by reciprocal multiply
    edd_back #(
        .MATRIX_DIM (MATRIX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_mask        (q_mask),
        .q_err         (q_err),
        .q_mirror      (q_mirror),
        .q_row         (q_row),
        .q_col         (q_col),
        .q_plane       (q_plane),
        .pop           (pop),
        .weights       (weights),
        .mtx           (mtx),
        .update_strobe (update_strobe),
        .target_row    (target_row),
        .target_col    (target_col),
        .target_plane  (target_plane),
        .share         (share),
        .last_update   (last_update)
    );

    a_no_accept_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
        deriving |-> busy)
        else $error("error_diffusion_distributor: ready during matrix derivation");

endmodule

`default_nettype wire

[hw/rtl/edd_fifo.sv]
// ============================================================================
// edd_fifo - small word queue between front and back
// Register-based FIFO, combinational read of the head word.
// ============================================================================
`default_nettype none

module edd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] dout,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("edd_fifo: push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("edd_fifo: pop from empty queue");

endmodule

`default_nettype wire

[hw/rtl/edd_cfg.sv]
// ============================================================================
// edd_cfg - APB register file and matrix derivation
// Holds weights and image size; after a weight write sweeps the matrix for sum
// and centre, then if usable runs a restoring division for the sum's reciprocal.
// ============================================================================
`default_nettype none

module edd_cfg import edd_pkg::*; #(
    parameter int MATRIX_DIM = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output weight_rows_t               weights,
    output logic      [IMG_W-1:0]      image_rows,
    output logic      [IMG_W-1:0]      image_cols,
    output mtx_info_t                  mtx,
    output logic                       deriving
);

    localparam int N  = MATRIX_DIM * MATRIX_DIM;
    localparam int EW = $clog2(N);

    weight_rows_t          weight_reg;
    logic [IMG_W-1:0]      image_rows_reg, image_cols_reg;
    reg_idx_t              widx;
    logic [2:0]            row_sel;
    logic                  wr_fire;
    logic                  weight_wr;

    drv_state_t            state_reg, state_next;
    logic [EW-1:0]         k_reg, k_next;
    logic [IDX_W-1:0]      si_reg, si_next, sj_reg, sj_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      crow_reg, crow_next, ccol_reg, ccol_next;
    logic                  enable_reg, enable_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [SUM_W:0]        rem_reg, rem_next;
    logic [RECIP_SHIFT-1:0] quo_reg, quo_next;
    logic [RECIP_W-1:0]    recip_reg, recip_next;

    logic [WEIGHT_W-1:0]   wtab [N];
    logic [WEIGHT_W-1:0]   cur_w;
    logic [SUM_W+1:0]      rem_try;
    logic                  rem_ge;

    assign pready  = 1'b1;
    assign widx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign row_sel = paddr[APB_ADDR_W-1:2];
    assign wr_fire = psel && penable && pwrite;

    always_comb
    begin
        weight_wr = 1'b0;
        if (wr_fire)
        begin
            case (widx) inside
                REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2,
                REG_WEIGHT_3, REG_WEIGHT_4: weight_wr = 1'b1;
                default:                    weight_wr = 1'b0;
            endcase
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg     <= '0;
            image_rows_reg <= IMG_W'(4096);
            image_cols_reg <= IMG_W'(4096);
        end
        else if (wr_fire)
        begin
            unique case (widx) inside
                REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2,
                REG_WEIGHT_3, REG_WEIGHT_4: weight_reg[row_sel] <= pwdata[ROW_W-1:0];
                REG_IMAGE_ROWS:             image_rows_reg <= pwdata[IMG_W-1:0];
                REG_IMAGE_COLS:             image_cols_reg <= pwdata[IMG_W-1:0];
                default:                    ;
            endcase
        end
    end

    // read-back
    always_comb
    begin
        prdata = '0;
        unique case (widx) inside
            REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2,
            REG_WEIGHT_3, REG_WEIGHT_4: prdata = APB_DATA_W'(weight_reg[row_sel]);
            REG_IMAGE_ROWS:             prdata = APB_DATA_W'(image_rows_reg);
            REG_IMAGE_COLS:             prdata = APB_DATA_W'(image_cols_reg);
            default:                    prdata = '0;
        endcase
    end

    // matrix entries in raster order
    always_comb
    begin
        for (int i = 0; i < MATRIX_DIM; i++)
        begin
            for (int j = 0; j < MATRIX_DIM; j++)
            begin
                wtab[i*MATRIX_DIM + j] = weight_at(weight_reg, i, j);
            end
        end
    end

    assign cur_w   = wtab[k_reg];
    assign rem_try = {rem_reg, 1'b1};
    assign rem_ge  = (rem_try >= (SUM_W+2)'(sum_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= DRV_IDLE;
            k_reg       <= '0;
            si_reg      <= '0;
            sj_reg      <= '0;
            sum_reg     <= '0;
            found_reg   <= 1'b0;
            crow_reg    <= '0;
            ccol_reg    <= '0;
            enable_reg  <= 1'b0;
            div_cnt_reg <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            recip_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            si_reg      <= si_next;
            sj_reg      <= sj_next;
            sum_reg     <= sum_next;
            found_reg   <= found_next;
            crow_reg    <= crow_next;
            ccol_reg    <= ccol_next;
            enable_reg  <= enable_next;
            div_cnt_reg <= div_cnt_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            recip_reg   <= recip_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        sum_next     = sum_reg;
        found_next   = found_reg;
        crow_next    = crow_reg;
        ccol_next    = ccol_reg;
        enable_next  = enable_reg;
        div_cnt_next = div_cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        recip_next   = recip_reg;

        unique case (state_reg)
            DRV_IDLE:
            begin
            end
            DRV_SWEEP:
            begin
                if (cur_w != '0)
                begin
                    sum_next = sum_reg + SUM_W'(cur_w);
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        if (sj_reg == '0)
                        begin
                            crow_next = si_reg - 1'b1;
                            ccol_next = IDX_W'(MATRIX_DIM - 1);
                        end
                        else
                        begin
                            crow_next = si_reg;
                            ccol_next = sj_reg - 1'b1;
                        end
                    end
                end
                if (k_reg == EW'(N - 1))
                begin
                    // top-left weight set, or no weight at all: matrix unusable
                    if (weight_at(weight_reg, 0, 0) != '0 || !(found_reg || cur_w != '0))
                    begin
                        state_next = DRV_IDLE;
                    end
                    else
                    begin
                        state_next   = DRV_DIVIDE;
                        div_cnt_next = '0;
                        rem_next     = '0;
                        quo_next     = '0;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    if (sj_reg == IDX_W'(MATRIX_DIM - 1))
                    begin
                        sj_next = '0;
                        si_next = si_reg + 1'b1;
                    end
                    else
                    begin
                        sj_next = sj_reg + 1'b1;
                    end
                end
            end
            DRV_DIVIDE:
            begin
                // dividend is all ones: floor((2^K - 1)/sum) + 1 = ceil(2^K/sum)
                rem_next = rem_ge ? (SUM_W+1)'(rem_try - (SUM_W+2)'(sum_reg))
                                  : rem_try[SUM_W:0];
                quo_next = {quo_reg[RECIP_SHIFT-2:0], rem_ge};
                if (div_cnt_reg == DIV_CNT_W'(RECIP_SHIFT - 1))
                begin
                    recip_next  = RECIP_W'(quo_next) + 1'b1;
                    enable_next = 1'b1;
                    state_next  = DRV_IDLE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = DRV_IDLE;
            end
        endcase

        // any weight write restarts the derivation
        if (weight_wr)
        begin
            state_next  = DRV_SWEEP;
            k_next      = '0;
            si_next     = '0;
            sj_next     = '0;
            sum_next    = '0;
            found_next  = 1'b0;
            enable_next = 1'b0;
        end
    end

    assign weights    = weight_reg;
    assign image_rows = image_rows_reg;
    assign image_cols = image_cols_reg;
    assign deriving   = (state_reg != DRV_IDLE);

    assign mtx.enable = enable_reg;
    assign mtx.sum    = sum_reg;
    assign mtx.crow   = crow_reg;
    assign mtx.ccol   = ccol_reg;
    assign mtx.recip  = recip_reg;

    a_write_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        weight_wr |=> (state_reg == DRV_SWEEP))
        else $error("edd_cfg: weight write did not restart derivation");

    a_disabled_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != DRV_IDLE) |-> !enable_reg)
        else $error("edd_cfg: matrix enabled during derivation");

endmodule

`default_nettype wire

[hw/rtl/edd_front.sv]
// ============================================================================
// edd_front - item intake and classification
// Checks the error, builds the mask of in-image nonzero matrix entries and
// hands non-empty items to the queue.
// ============================================================================
`default_nettype none

module edd_front import edd_pkg::*; #(
    parameter int MATRIX_DIM = 5,
    parameter int COORD_BITS = 12,
    parameter int PIXEL_MAX  = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [ERR_W-1:0]       quant_error,
    input  wire logic                          mirror,
    input  wire logic        [COORD_BITS-1:0]  pixel_row,
    input  wire logic        [COORD_BITS-1:0]  pixel_col,
    input  wire logic        [PLANE_W-1:0]     color_plane,
    input  wire weight_rows_t                  weights,
    input  wire logic        [IMG_W-1:0]       image_rows,
    input  wire logic        [IMG_W-1:0]       image_cols,
    input  wire mtx_info_t                     mtx,
    input  wire logic                          deriving,
    input  wire logic                          q_full,
    output logic                               push,
    output logic [MATRIX_DIM*MATRIX_DIM-1:0]   p_mask,
    output logic signed [ERR_W-1:0]            p_err,
    output logic                               p_mirror,
    output logic [COORD_BITS-1:0]              p_row,
    output logic [COORD_BITS-1:0]              p_col,
    output logic [PLANE_W-1:0]                 p_plane
);

    localparam int N   = MATRIX_DIM * MATRIX_DIM;
    localparam int CW  = (COORD_BITS + 2 > IMG_W + 1) ? COORD_BITS + 2 : IMG_W + 1;
    localparam logic [CW-1:0] CLIM = CW'(1) << COORD_BITS;
    localparam logic [16:0]   PMAX = 17'(PIXEL_MAX);

    logic                   stg_valid_reg, stg_valid_next;
    logic [N-1:0]           mask_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic                   mirror_reg;
    logic [COORD_BITS-1:0]  row_reg, col_reg;
    logic [PLANE_W-1:0]     plane_reg;

    logic                   accept;
    logic [ERR_W-1:0]       err_mag;
    logic                   err_ok;
    logic [CW-1:0]          lim_r, lim_c;
    logic [CW-1:0]          tr, tc;
    logic [MATRIX_DIM-1:0]  row_ok, col_ok;
    logic [N-1:0]           mask;
    logic                   keep;

    assign push   = stg_valid_reg && !q_full;
    assign busy   = deriving || (stg_valid_reg && q_full);
    assign accept = start && !busy;

    always_comb
    begin
        err_mag = quant_error[ERR_W-1] ? ERR_W'(-quant_error) : ERR_W'(quant_error);
        err_ok  = (quant_error != '0) && (17'(err_mag) <= PMAX);

        lim_r = (CW'(image_rows) > CLIM) ? CLIM : CW'(image_rows);
        lim_c = (CW'(image_cols) > CLIM) ? CLIM : CW'(image_cols);

        tr = '0;
        tc = '0;
        for (int i = 0; i < MATRIX_DIM; i++)
        begin
            tr = CW'(pixel_row) + CW'(i) - CW'(mtx.crow);
            row_ok[i] = !tr[CW-1] && (tr < lim_r);
        end
        for (int j = 0; j < MATRIX_DIM; j++)
        begin
            if (mirror)
            begin
                tc = CW'(pixel_col) + CW'(mtx.ccol) - CW'(j);
            end
            else
            begin
                tc = CW'(pixel_col) + CW'(j) - CW'(mtx.ccol);
            end
            col_ok[j] = !tc[CW-1] && (tc < lim_c);
        end
        for (int i = 0; i < MATRIX_DIM; i++)
        begin
            for (int j = 0; j < MATRIX_DIM; j++)
            begin
                mask[i*MATRIX_DIM + j] = (weight_at(weights, i, j) != '0)
                                         && row_ok[i] && col_ok[j];
            end
        end
        keep = mtx.enable && err_ok && (mask != '0);

        stg_valid_next = stg_valid_reg;
        if (accept)
        begin
            stg_valid_next = keep;
        end
        else if (push)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg   <= mask;
            err_reg    <= quant_error;
            mirror_reg <= mirror;
            row_reg    <= pixel_row;
            col_reg    <= pixel_col;
            plane_reg  <= color_plane;
        end
    end

    assign p_mask   = mask_reg;
    assign p_err    = err_reg;
    assign p_mirror = mirror_reg;
    assign p_row    = row_reg;
    assign p_col    = col_reg;
    assign p_plane  = plane_reg;

endmodule

`default_nettype wire

[hw/rtl/edd_back.sv]
// ============================================================================
// edd_back - update issue and share arithmetic
// Walks the set mask bits lowest first, one update per cycle; stage A forms
// target and numerator, stage B divides by reciprocal multiply.
// ============================================================================
`default_nettype none

module edd_back import edd_pkg::*; #(
    parameter int MATRIX_DIM = 5,
    parameter int COORD_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire logic [MATRIX_DIM*MATRIX_DIM-1:0]  q_mask,
    input  wire logic signed [ERR_W-1:0]           q_err,
    input  wire logic                              q_mirror,
    input  wire logic [COORD_BITS-1:0]             q_row,
    input  wire logic [COORD_BITS-1:0]             q_col,
    input  wire logic [PLANE_W-1:0]                q_plane,
    output logic                                   pop,
    input  wire weight_rows_t                      weights,
    input  wire mtx_info_t                         mtx,
    output logic                                   update_strobe,
    output logic [COORD_BITS-1:0]                  target_row,
    output logic [COORD_BITS-1:0]                  target_col,
    output logic [PLANE_W-1:0]                     target_plane,
    output logic signed [SHARE_W-1:0]              share,
    output logic                                   last_update
);

    localparam int N  = MATRIX_DIM * MATRIX_DIM;
    localparam int CW = COORD_BITS + 2;
    localparam int PW = ERR_W + WEIGHT_W + 1;

    // current item
    logic [N-1:0]            mask_reg, mask_next;
    logic signed [ERR_W-1:0] err_reg;
    logic                    mirror_reg;
    logic [COORD_BITS-1:0]   row_reg, col_reg;
    logic [PLANE_W-1:0]      plane_reg;

    // stage A
    logic                    a_valid_reg;
    logic [COORD_BITS-1:0]   a_row_reg, a_col_reg;
    logic [PLANE_W-1:0]      a_plane_reg;
    logic                    a_last_reg;
    logic signed [NUM_W-1:0] a_num_reg;

    // stage B / outputs
    logic                    strobe_reg;
    logic [COORD_BITS-1:0]   out_row_reg, out_col_reg;
    logic [PLANE_W-1:0]      out_plane_reg;
    logic                    out_last_reg;
    logic signed [SHARE_W-1:0] out_share_reg;

    logic                    active;
    logic [N-1:0]            low, rest;
    logic                    last;
    logic [IDX_W-1:0]        sel_i, sel_j;
    logic [WEIGHT_W-1:0]     sel_w;
    logic signed [PW-1:0]    wprod;
    logic signed [NUM_W-1:0] num;
    logic [CW-1:0]           tr_full, tc_full;

    logic                    num_neg;
    logic [NUM_W-1:0]        num_abs;
    logic [MAG_W+RECIP_W-1:0] prod;
    logic [SHARE_W-1:0]      quo;

    assign active = (mask_reg != '0);
    assign low    = mask_reg & (~mask_reg + 1'b1);   // lowest pending entry
    assign rest   = mask_reg & ~low;
    assign last   = (rest == '0);
    assign pop    = !q_empty && (!active || last);

    always_comb
    begin
        sel_i = '0;
        sel_j = '0;
        sel_w = '0;
        for (int i = 0; i < MATRIX_DIM; i++)
        begin
            for (int j = 0; j < MATRIX_DIM; j++)
            begin
                if (low[i*MATRIX_DIM + j])
                begin
                    sel_i = sel_i | IDX_W'(i);
                    sel_j = sel_j | IDX_W'(j);
                    sel_w = sel_w | weight_at(weights, i, j);
                end
            end
        end

        wprod   = $signed({1'b0, sel_w}) * err_reg;
        num     = NUM_W'(wprod + $signed(PW'(mtx.sum >> 1)));
        tr_full = CW'(row_reg) + CW'(sel_i) - CW'(mtx.crow);
        if (mirror_reg)
        begin
            tc_full = CW'(col_reg) + CW'(mtx.ccol) - CW'(sel_j);
        end
        else
        begin
            tc_full = CW'(col_reg) + CW'(sel_j) - CW'(mtx.ccol);
        end

        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = q_mask;
        end
        else if (active)
        begin
            mask_next = rest;
        end
    end

    // truncating division: |num| * ceil(2^K/sum) >> K, sign reapplied
    always_comb
    begin
        num_neg = a_num_reg[NUM_W-1];
        num_abs = num_neg ? NUM_W'(-a_num_reg) : NUM_W'(a_num_reg);
        prod    = num_abs[MAG_W-1:0] * mtx.recip;
        quo     = prod[RECIP_SHIFT +: SHARE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            a_valid_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            mask_reg    <= mask_next;
            a_valid_reg <= active;
            strobe_reg  <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            err_reg    <= q_err;
            mirror_reg <= q_mirror;
            row_reg    <= q_row;
            col_reg    <= q_col;
            plane_reg  <= q_plane;
        end
        a_row_reg     <= tr_full[COORD_BITS-1:0];
        a_col_reg     <= tc_full[COORD_BITS-1:0];
        a_plane_reg   <= plane_reg;
        a_last_reg    <= last;
        a_num_reg     <= num;
        out_row_reg   <= a_row_reg;
        out_col_reg   <= a_col_reg;
        out_plane_reg <= a_plane_reg;
        out_last_reg  <= a_last_reg;
        out_share_reg <= num_neg ? -$signed(quo) : $signed(quo);
    end

    assign update_strobe = strobe_reg;
    assign target_row    = out_row_reg;
    assign target_col    = out_col_reg;
    assign target_plane  = out_plane_reg;
    assign share         = out_share_reg;
    assign last_update   = out_last_reg;

    a_issue_flows: assert property (@(posedge clk) disable iff (!rst_n)
        active |=> a_valid_reg ##1 strobe_reg)
        else $error("edd_back: pending entry did not reach the result port");

    a_one_pick: assert property (@(posedge clk) disable iff (!rst_n)
        active |-> $onehot(low))
        else $error("edd_back: issue picked other than one entry");

endmodule

`default_nettype wire
